>>> design/fct_pkg.sv
`default_nettype none
package fct_pkg;

  // The table size must be a power of two.
  localparam int TABLE_ENTRIES = 1024;
  localparam int PROBE_LIMIT = 8;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int PROBE_W = $clog2(PROBE_LIMIT + 1);

  localparam logic [15:0] ETH_HDR_LEN = 16'd14;
  localparam logic [3:0] IP_VERSION_FOUR = 4'd4;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic [2:0] ST_HIT = 3'd0;
  localparam logic [2:0] ST_NEW = 3'd1;
  localparam logic [2:0] ST_NOT_IPV4 = 3'd2;
  localparam logic [2:0] ST_NOT_L4 = 3'd3;
  localparam logic [2:0] ST_TRUNC = 3'd4;
  localparam logic [2:0] ST_FULL = 3'd5;

  typedef struct packed {
    logic valid;
    logic [63:0] addr_key;
    logic [39:0] port_proto_key;
    logic [31:0] packets;
    logic [31:0] bytes;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef struct packed {
    logic capture;
    logic clr;
    logic [IDX_W-1:0] clr_addr;
    logic probe_first;
    logic probe_next;
    logic commit;
    logic fail_pre;
    logic fail_full;
  } ctl_cmd_t;

  typedef struct packed {
    logic pre_ok;
    logic slot_empty;
    logic slot_hit;
  } dp_stat_t;

endpackage
`default_nettype wire

>>> design/fct_ifs.sv
`default_nettype none
interface fct_in_if;
  import fct_pkg::*;
  logic valid;
  logic ready;
  logic [7:0] frame_byte;
  logic last_byte;
  logic [15:0] wire_length;
  modport source(output valid, frame_byte, last_byte, wire_length, input ready);
  modport sink(input valid, frame_byte, last_byte, wire_length, output ready);
endinterface

interface fct_out_if;
  import fct_pkg::*;
  logic valid;
  logic ready;
  logic [2:0] status;
  logic [31:0] source_address;
  logic [31:0] dest_address;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [7:0] ip_protocol;
  logic [IDX_W-1:0] entry_index;
  logic [31:0] flow_packets;
  logic [31:0] flow_bytes;
  modport source(output valid, status, source_address, dest_address, source_port,
                 dest_port, ip_protocol, entry_index, flow_packets, flow_bytes,
                 input ready);
  modport sink(input valid, status, source_address, dest_address, source_port,
               dest_port, ip_protocol, entry_index, flow_packets, flow_bytes,
               output ready);
endinterface
`default_nettype wire

>>> design/fct_ram.sv
`default_nettype none
module fct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [$clog2(DEPTH)-1:0] waddr,
  input wire logic [WIDTH-1:0] wdata,
  input wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> design/fct_datapath.sv
`default_nettype none
module fct_datapath import fct_pkg::*; (
  input wire logic clk,
  input wire ctl_cmd_t cmd,
  output dp_stat_t stat,
  input wire logic [7:0] frame_byte,
  input wire logic last_byte,
  input wire logic [15:0] wire_length,
  output logic [2:0] status,
  output logic [31:0] source_address,
  output logic [31:0] dest_address,
  output logic [15:0] source_port,
  output logic [15:0] dest_port,
  output logic [7:0] ip_protocol,
  output logic [IDX_W-1:0] entry_index,
  output logic [31:0] flow_packets,
  output logic [31:0] flow_bytes,
  input wire logic rst
);
  logic [15:0] byte_offset;
  logic [7:0] vhl;
  logic [7:0] proto;
  logic [63:0] addrs;
  logic [31:0] ports;
  logic [7:0] vhl_next;
  logic [7:0] proto_next;
  logic [63:0] addrs_next;
  logic [31:0] ports_next;
  logic [15:0] tpos;
  logic [15:0] rel;
  logic [15:0] arel;

  logic [7:0] s_vhl;
  logic [7:0] s_proto;
  logic [63:0] s_addrs;
  logic [31:0] s_ports;
  logic [16:0] s_len;
  logic [15:0] s_wire;

  logic [2:0] pre_status;
  logic pre_ok;
  logic [16:0] s_tend;
  logic [31:0] h32;
  logic [15:0] h16;
  logic [16:0] h17;
  logic [IDX_W-1:0] hash_slot;
  logic [IDX_W-1:0] paddr;
  logic [IDX_W-1:0] raddr;
  logic ram_we;
  logic [IDX_W-1:0] waddr;
  slot_t wslot;
  slot_t rslot;
  slot_t upd;

  always_comb begin
    vhl_next = (byte_offset == ETH_HDR_LEN) ? frame_byte : vhl;
    tpos = ETH_HDR_LEN + {10'd0, vhl_next[3:0], 2'b00};
    proto_next = (byte_offset == ETH_HDR_LEN + 16'd9) ? frame_byte : proto;
    addrs_next = addrs;
    arel = byte_offset - (ETH_HDR_LEN + 16'd12);
    if (byte_offset >= ETH_HDR_LEN + 16'd12 && byte_offset < ETH_HDR_LEN + 16'd20) begin
      addrs_next[8*(7-arel[2:0]) +: 8] = frame_byte;
    end
    ports_next = ports;
    rel = byte_offset - tpos;
    if (byte_offset >= tpos && byte_offset < tpos + 16'd4) begin
      ports_next[8*(3-rel[1:0]) +: 8] = frame_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset <= '0;
      vhl <= '0;
      proto <= '0;
      addrs <= '0;
      ports <= '0;
    end else if (cmd.capture) begin
      if (last_byte) begin
        byte_offset <= '0;
        vhl <= '0;
        proto <= '0;
        addrs <= '0;
        ports <= '0;
      end else begin
        byte_offset <= (byte_offset == 16'hFFFF) ? byte_offset : byte_offset + 16'd1;
        vhl <= vhl_next;
        proto <= proto_next;
        addrs <= addrs_next;
        ports <= ports_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture && last_byte) begin
      s_vhl <= vhl_next;
      s_proto <= proto_next;
      s_addrs <= addrs_next;
      s_ports <= ports_next;
      s_len <= {1'b0, byte_offset} + 17'd1;
      s_wire <= wire_length;
    end
  end

  always_comb begin
    s_tend = 17'd18 + {11'd0, s_vhl[3:0], 2'b00};
    pre_ok = 1'b0;
    if (s_len < 17'd15) begin
      pre_status = ST_TRUNC;
    end else if (s_vhl[7:4] != IP_VERSION_FOUR) begin
      pre_status = ST_NOT_IPV4;
    end else if (s_len < 17'd24) begin
      pre_status = ST_TRUNC;
    end else if (s_proto != PROTO_TCP && s_proto != PROTO_UDP) begin
      pre_status = ST_NOT_L4;
    end else if (s_len < 17'd34 || s_len < s_tend) begin
      pre_status = ST_TRUNC;
    end else begin
      pre_status = ST_HIT;
      pre_ok = 1'b1;
    end
  end

  always_comb begin
    h32 = s_addrs[63:32] ^ s_addrs[31:0] ^ s_ports ^ {24'd0, s_proto};
    h16 = h32[31:16] ^ h32[15:0];
    h17 = {1'b0, h16};
    hash_slot = h17[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.probe_first) begin
      paddr <= hash_slot;
    end else if (cmd.probe_next) begin
      paddr <= paddr + 1'b1;
    end
  end

  assign raddr = cmd.probe_first ? hash_slot : paddr + 1'b1;

  always_comb begin
    upd.valid = 1'b1;
    upd.addr_key = s_addrs;
    upd.port_proto_key = {s_ports, s_proto};
    if (rslot.valid) begin
      upd.packets = rslot.packets + 32'd1;
      upd.bytes = rslot.bytes + {16'd0, s_wire};
    end else begin
      upd.packets = 32'd1;
      upd.bytes = {16'd0, s_wire};
    end
  end

  assign stat.pre_ok = pre_ok;
  assign stat.slot_empty = !rslot.valid;
  assign stat.slot_hit = rslot.valid && rslot.addr_key == s_addrs &&
                         rslot.port_proto_key == {s_ports, s_proto};

  assign ram_we = cmd.clr || cmd.commit;
  assign waddr = cmd.clr ? cmd.clr_addr : paddr;
  assign wslot = cmd.clr ? '0 : upd;

  fct_ram #(.WIDTH(SLOT_W), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk(clk),
    .we(ram_we),
    .waddr(waddr),
    .wdata(wslot),
    .raddr(raddr),
    .rdata(rslot)
  );

  always_ff @(posedge clk) begin
    if (cmd.commit || cmd.fail_pre || cmd.fail_full) begin
      source_address <= s_addrs[63:32];
      dest_address <= s_addrs[31:0];
      source_port <= s_ports[31:16];
      dest_port <= s_ports[15:0];
      ip_protocol <= s_proto;
      if (cmd.commit) begin
        status <= rslot.valid ? ST_HIT : ST_NEW;
        entry_index <= paddr;
        flow_packets <= upd.packets;
        flow_bytes <= upd.bytes;
      end else begin
        status <= cmd.fail_full ? ST_FULL : pre_status;
        entry_index <= '0;
        flow_packets <= '0;
        flow_bytes <= '0;
      end
    end
  end
endmodule
`default_nettype wire

>>> design/fct_ctrl.sv
`default_nettype none
module fct_ctrl import fct_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_last,
  output logic in_ready,
  output logic out_valid,
  input wire logic out_ready,
  output ctl_cmd_t cmd,
  input wire dp_stat_t stat
);
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_OUT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [IDX_W-1:0] clr_cnt;
  logic [PROBE_W-1:0] probe_cnt;

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.clr_addr = clr_cnt;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (clr_cnt == IDX_W'(TABLE_ENTRIES - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid && in_last) state_next = S_EVAL;
      end
      S_EVAL: begin
        if (stat.pre_ok) begin
          cmd.probe_first = 1'b1;
          state_next = S_CHECK;
        end else begin
          cmd.fail_pre = 1'b1;
          state_next = S_OUT;
        end
      end
      S_CHECK: begin
        if (stat.slot_empty || stat.slot_hit) begin
          cmd.commit = 1'b1;
          state_next = S_OUT;
        end else if (probe_cnt == PROBE_W'(PROBE_LIMIT - 1)) begin
          cmd.fail_full = 1'b1;
          state_next = S_OUT;
        end else begin
          cmd.probe_next = 1'b1;
        end
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      probe_cnt <= '0;
    end else begin
      state <= state_next;
      if (cmd.clr) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.probe_first) begin
        probe_cnt <= '0;
      end else if (cmd.probe_next) begin
        probe_cnt <= probe_cnt + 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

>>> design/ipv4_flow_counter_table.sv
// Frame bytes are taken one per cycle; a byte that is not the last gives no result.
// After the last byte, the header checks run in the EVAL state; a frame that they reject
// goes straight to the result, else the table is probed, up to PROBE_LIMIT slots, one probe
// per cycle through the registered read port of the table RAM.
// No byte is taken from the last byte until the result transaction completes.
// Reset is synchronous; afterwards the table RAM is cleared one slot per cycle, all
// TABLE_ENTRIES slots (1024), before the first byte is taken.
`default_nettype none
module ipv4_flow_counter_table import fct_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  fct_in_if.sink frame,
  fct_out_if.source result
);
  ctl_cmd_t cmd;
  dp_stat_t stat;

  fct_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(frame.valid),
    .in_last(frame.last_byte),
    .in_ready(frame.ready),
    .out_valid(result.valid),
    .out_ready(result.ready),
    .cmd(cmd),
    .stat(stat)
  );

  fct_datapath u_dp (
    .clk(clk),
    .cmd(cmd),
    .stat(stat),
    .frame_byte(frame.frame_byte),
    .last_byte(frame.last_byte),
    .wire_length(frame.wire_length),
    .status(result.status),
    .source_address(result.source_address),
    .dest_address(result.dest_address),
    .source_port(result.source_port),
    .dest_port(result.dest_port),
    .ip_protocol(result.ip_protocol),
    .entry_index(result.entry_index),
    .flow_packets(result.flow_packets),
    .flow_bytes(result.flow_bytes),
    .rst(rst)
  );
endmodule
`default_nettype wire
